### hw/rtl/bchc_pkg.sv
package bchc_pkg;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_HOLD   = 3'd3,
        EV_LONG   = 3'd4
    } event_code_t;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int STAMP_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DC_GAP     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD  = 8'd3;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET  = 16'd20;
    localparam logic [CFG_DATA_W-1:0] DC_GAP_RESET    = 16'd250;
    localparam logic [CFG_DATA_W-1:0] HOLD_RESET      = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] LONG_HOLD_RESET = 16'd3000;

endpackage

### hw/rtl/button_click_hold_classifier.sv
// Button click / double click / hold / long hold classifier.
//
// Input stream (s_t*): one word per millisecond tick, s_tdata[0] is the sampled
// button level (0 pressed, 1 released). Every accepted word yields exactly one
// result word on m_t*, m_tdata[2:0] carrying the event code (none, click,
// double click, hold, long hold).
//
// The word accepted at one edge shows on m_tvalid after that edge. Throughput
// is one word per cycle while the receiver keeps up; the tick state update and
// classification are one registered pass through two 32-bit subtractors and
// their compares. A single output register parts the channels: s_tready is
// high while that register is empty or being taken, so a stalled receiver
// holds the result and stalls the input one word deep.
//
// Configuration (cfg_*): register index and 16-bit value, always ready. Write
// only while no words are in flight. Unknown indexes are ignored.
//
// Reset (aresetn low, synchronous): tick counter zero, stamps all ones, level
// released, single flag set, other flags cleared, timing registers back to
// 20/250/1000/3000 ticks, output register empty.
module button_click_hold_classifier (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [0] pin_level
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [2:0] event_code
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bchc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bchc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bchc_pkg::*;

    logic [CFG_DATA_W-1:0] debounce_reg, dc_gap_reg, hold_reg, long_hold_reg;

    logic [STAMP_W-1:0] tick_reg, tick_next;
    logic [STAMP_W-1:0] press_reg, press_next;
    logic [STAMP_W-1:0] release_reg, release_next;
    logic               last_level_reg, last_level_next;
    logic               dc_wait_reg, dc_wait_next;
    logic               dc_on_rel_reg, dc_on_rel_next;
    logic               single_reg, single_next;
    logic               ignore_rel_reg, ignore_rel_next;
    logic               wait_rel_reg, wait_rel_next;
    logic               hold_done_reg, hold_done_next;
    logic               long_done_reg, long_done_next;

    logic               m_valid_reg, m_valid_next;
    event_code_t        m_event_reg, m_event_next;

    logic               s_fire;
    logic               level;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign level     = s_tdata[0];
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, m_event_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RESET;
            dc_gap_reg    <= DC_GAP_RESET;
            hold_reg      <= HOLD_RESET;
            long_hold_reg <= LONG_HOLD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE:  debounce_reg  <= cfg_data;
                REG_DC_GAP:    dc_gap_reg    <= cfg_data;
                REG_HOLD:      hold_reg      <= cfg_data;
                REG_LONG_HOLD: long_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [STAMP_W-1:0] since_up;
        logic [STAMP_W-1:0] since_down;
        logic [STAMP_W-1:0] debounce_w, gap_w, hold_w, long_w;
        logic               press_edge;
        logic               release_edge;
        logic               release_taken;
        event_code_t        ev;

        debounce_w = {{(STAMP_W-CFG_DATA_W){1'b0}}, debounce_reg};
        gap_w      = {{(STAMP_W-CFG_DATA_W){1'b0}}, dc_gap_reg};
        hold_w     = {{(STAMP_W-CFG_DATA_W){1'b0}}, hold_reg};
        long_w     = {{(STAMP_W-CFG_DATA_W){1'b0}}, long_hold_reg};

        since_up   = tick_reg - release_reg;
        since_down = tick_reg - press_reg;

        tick_next       = tick_reg;
        press_next      = press_reg;
        release_next    = release_reg;
        last_level_next = last_level_reg;
        dc_wait_next    = dc_wait_reg;
        dc_on_rel_next  = dc_on_rel_reg;
        single_next     = single_reg;
        ignore_rel_next = ignore_rel_reg;
        wait_rel_next   = wait_rel_reg;
        hold_done_next  = hold_done_reg;
        long_done_next  = long_done_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_event_next    = m_event_reg;
        ev              = EV_NONE;

        press_edge    = !level && last_level_reg && (since_up > debounce_w);
        release_edge  = !press_edge && level && !last_level_reg
                        && (since_down > debounce_w);
        release_taken = release_edge && !ignore_rel_reg;

        if (press_edge) begin
            press_next      = tick_reg;
            ignore_rel_next = 1'b0;
            wait_rel_next   = 1'b0;
            single_next     = 1'b1;
            hold_done_next  = 1'b0;
            long_done_next  = 1'b0;
            dc_on_rel_next  = (since_up < gap_w) && !dc_on_rel_reg && dc_wait_reg;
            dc_wait_next    = 1'b0;
        end else if (release_taken) begin
            release_next = tick_reg;
            if (!dc_on_rel_reg) begin
                dc_wait_next = 1'b1;
            end else begin
                ev             = EV_DOUBLE;
                dc_on_rel_next = 1'b0;
                dc_wait_next   = 1'b0;
                single_next    = 1'b0;
            end
        end

        // a stamp taken this tick means zero elapsed time
        if (release_taken) since_up = '0;
        if (press_edge) since_down = '0;

        if (level && (since_up >= gap_w) && dc_wait_next && !dc_on_rel_next
            && single_next && (ev != EV_DOUBLE)) begin
            ev           = EV_CLICK;
            dc_wait_next = 1'b0;
        end

        if (!level && (since_down >= hold_w)) begin
            if (!hold_done_next) begin
                ev              = EV_HOLD;
                wait_rel_next   = 1'b1;
                ignore_rel_next = 1'b1;
                dc_on_rel_next  = 1'b0;
                dc_wait_next    = 1'b0;
                hold_done_next  = 1'b1;
            end
            if ((since_down >= long_w) && !long_done_next) begin
                ev             = EV_LONG;
                long_done_next = 1'b1;
            end
        end

        last_level_next = level;
        tick_next       = tick_reg + 1'b1;

        if (s_fire) begin
            m_valid_next = 1'b1;
            m_event_next = ev;
        end else begin
            tick_next       = tick_reg;
            press_next      = press_reg;
            release_next    = release_reg;
            last_level_next = last_level_reg;
            dc_wait_next    = dc_wait_reg;
            dc_on_rel_next  = dc_on_rel_reg;
            single_next     = single_reg;
            ignore_rel_next = ignore_rel_reg;
            wait_rel_next   = wait_rel_reg;
            hold_done_next  = hold_done_reg;
            long_done_next  = long_done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            press_reg      <= '1;
            release_reg    <= '1;
            last_level_reg <= 1'b1;
            dc_wait_reg    <= 1'b0;
            dc_on_rel_reg  <= 1'b0;
            single_reg     <= 1'b1;
            ignore_rel_reg <= 1'b0;
            wait_rel_reg   <= 1'b0;
            hold_done_reg  <= 1'b0;
            long_done_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            tick_reg       <= tick_next;
            press_reg      <= press_next;
            release_reg    <= release_next;
            last_level_reg <= last_level_next;
            dc_wait_reg    <= dc_wait_next;
            dc_on_rel_reg  <= dc_on_rel_next;
            single_reg     <= single_next;
            ignore_rel_reg <= ignore_rel_next;
            wait_rel_reg   <= wait_rel_next;
            hold_done_reg  <= hold_done_next;
            long_done_reg  <= long_done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_event_reg <= m_event_next;
    end

endmodule

### hw/rtl/bchc_checker.sv
module bchc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import bchc_pkg::*;

    // a held result word keeps its value
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // no input word may be taken while the output register is full and stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted over a stalled result");

    // every accepted word gives a result in the next cycle
    a_one_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("result missing one cycle after input");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] == 5'd0) && (m_tdata[2:0] <= EV_LONG))
        else $error("event code out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind button_click_hold_classifier bchc_checker u_bchc_checker (.*);
